[src/slpd_pkg.sv]
// Shared constants and beat types for the streaming local peak detector.
`timescale 1ns / 1ps

package slpd_pkg;

    // Field widths.
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 16;
    localparam int COUNT_BITS  = 16;

    // Saturation limits for the sample index and the peak counter.
    localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // One input beat: a signed sample and the end-of-record mark.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } sample_beat_t;

    // One result beat: a detected peak.
    typedef struct packed {
        logic        [INDEX_BITS-1:0]  peak_index;
        logic signed [SAMPLE_BITS-1:0] peak_height;
        logic        [COUNT_BITS-1:0]  peaks_so_far;
        logic                          index_overflow;
    } peak_beat_t;

endpackage

[src/slpd_core.sv]
// Detection state and combinational peak decision for each accepted sample.
`timescale 1ns / 1ps

module slpd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  slpd_pkg::sample_beat_t beat,
    output logic                  emit,
    output slpd_pkg::peak_beat_t  result
);

    logic signed [slpd_pkg::SAMPLE_BITS-1:0] previous_sample_reg, previous_sample_next;
    logic                                    have_previous_reg, have_previous_next;
    logic                                    candidate_open_reg, candidate_open_next;
    logic [slpd_pkg::INDEX_BITS-1:0]         candidate_position_reg, candidate_position_next;
    logic [slpd_pkg::INDEX_BITS-1:0]         sample_position_reg, sample_position_next;
    logic [slpd_pkg::COUNT_BITS-1:0]         peak_count_reg, peak_count_next;
    logic                                    overflow_seen_reg, overflow_seen_next;

    logic [slpd_pkg::INDEX_BITS-1:0] position;
    logic                            overflow_now;
    logic                            rise;
    logic                            fall;

    // Position of this sample, saturating at the top of the index range.
    always_comb
    begin
        overflow_now = have_previous_reg && (sample_position_reg == slpd_pkg::INDEX_MAX);
        if (!have_previous_reg)
        begin
            position = '0;
        end
        else if (overflow_now)
        begin
            position = slpd_pkg::INDEX_MAX;
        end
        else
        begin
            position = sample_position_reg + 1'b1;
        end
    end

    // Compare against the previous sample.
    assign rise = have_previous_reg && ($signed(beat.sample) > previous_sample_reg);
    assign fall = have_previous_reg && candidate_open_reg
                  && ($signed(beat.sample) < previous_sample_reg);
    assign emit = accept && fall;

    // Next state; the end of a record returns everything to reset values.
    always_comb
    begin
        overflow_seen_next      = overflow_seen_reg || overflow_now;
        previous_sample_next    = beat.sample;
        have_previous_next      = 1'b1;
        sample_position_next    = position;
        candidate_open_next     = candidate_open_reg;
        candidate_position_next = candidate_position_reg;
        peak_count_next         = peak_count_reg;
        if (rise)
        begin
            candidate_open_next     = 1'b1;
            candidate_position_next = position;
        end
        else if (fall)
        begin
            candidate_open_next = 1'b0;
            if (peak_count_reg != slpd_pkg::COUNT_MAX)
            begin
                peak_count_next = peak_count_reg + 1'b1;
            end
        end

        result.peak_index     = candidate_position_reg;
        result.peak_height    = previous_sample_reg;
        result.peaks_so_far   = peak_count_next;
        result.index_overflow = overflow_seen_next;

        if (beat.last_sample)
        begin
            overflow_seen_next      = 1'b0;
            previous_sample_next    = '0;
            have_previous_next      = 1'b0;
            sample_position_next    = '0;
            candidate_open_next     = 1'b0;
            candidate_position_next = '0;
            peak_count_next         = '0;
        end
    end

    // State registers, updated once per accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_sample_reg    <= '0;
            have_previous_reg      <= 1'b0;
            candidate_open_reg     <= 1'b0;
            candidate_position_reg <= '0;
            sample_position_reg    <= '0;
            peak_count_reg         <= '0;
            overflow_seen_reg      <= 1'b0;
        end
        else if (accept)
        begin
            previous_sample_reg    <= previous_sample_next;
            have_previous_reg      <= have_previous_next;
            candidate_open_reg     <= candidate_open_next;
            candidate_position_reg <= candidate_position_next;
            sample_position_reg    <= sample_position_next;
            peak_count_reg         <= peak_count_next;
            overflow_seen_reg      <= overflow_seen_next;
        end
    end

    // A peak is only reported while a candidate is open.
    assert property (@(posedge clk) disable iff (!rst_n) emit |-> candidate_open_reg)
        else $error("peak emitted without an open candidate");

    // The end of a record clears the history.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && beat.last_sample) |=> (!have_previous_reg && peak_count_reg == '0))
        else $error("state not cleared after last sample");

    // Overflow is only flagged once the index has saturated.
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_seen_reg |-> (sample_position_reg == slpd_pkg::INDEX_MAX))
        else $error("overflow flagged below saturated index");

endmodule

[src/slpd_skid.sv]
// Two-entry result buffer that lets new samples enter while a peak waits.
`timescale 1ns / 1ps

module slpd_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  slpd_pkg::peak_beat_t push_beat,
    output logic                 space,
    output logic                 peak_valid,
    input  logic                 peak_ready,
    output slpd_pkg::peak_beat_t peak_beat
);

    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    slpd_pkg::peak_beat_t main_reg;
    slpd_pkg::peak_beat_t skid_reg;
    logic                 pop;

    assign pop        = main_valid_reg && peak_ready;
    assign space      = !skid_valid_reg;
    assign peak_valid = main_valid_reg;
    assign peak_beat  = main_reg;

    // Valid flags for the head and the spill entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload moves: spill entry refills the head first.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_beat;
            end
            else
            begin
                skid_reg <= push_beat;
            end
        end
    end

    // The spill entry is only used behind a full head.
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> main_valid_reg)
        else $error("spill entry holds data while head is empty");

    // Nothing is pushed while the buffer is full.
    assert property (@(posedge clk) disable iff (!rst_n) !(push && skid_valid_reg))
        else $error("push into full result buffer");

    // A waiting peak beat stays valid and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (peak_valid && !peak_ready) |=> (peak_valid && $stable(peak_beat)))
        else $error("peak beat changed while waiting");

endmodule

[src/streaming_local_peak_detector_top.sv]
// Top level of the streaming local peak detector.
`timescale 1ns / 1ps

// Takes one signed sample per beat, with last_sample marking the end of a record,
// and reports each local maximum (a strict rise, an optional flat run, then a
// strict fall) as one peak beat carrying the index of the plateau's first sample,
// its height, the running peak count and an index overflow flag. A sample is
// taken in every cycle: the decision is two compares against the previous sample
// and a few register updates, settled before the accepting edge, and the peak
// lands in a two-entry output buffer at that edge, so peak_valid is high in the
// following cycle. The input only stalls when both buffer entries hold peaks
// that the downstream side has not taken. The first and last samples of a
// record are never peaks, and all state clears after the last.
module streaming_local_peak_detector_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  slpd_pkg::sample_beat_t sample_beat,
    output logic                   peak_valid,
    input  logic                   peak_ready,
    output slpd_pkg::peak_beat_t   peak_beat
);

    logic                 accept;
    logic                 emit;
    logic                 space;
    slpd_pkg::peak_beat_t result;

    assign sample_ready = space;
    assign accept       = sample_valid && space;

    // Detection logic and history registers.
    slpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .beat   (sample_beat),
        .emit   (emit),
        .result (result)
    );

    // Result register with spill entry.
    slpd_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_beat  (result),
        .space      (space),
        .peak_valid (peak_valid),
        .peak_ready (peak_ready),
        .peak_beat  (peak_beat)
    );

endmodule
